### rtl/core/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared widths, constants, types and helpers for the Hamming SEC decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hsd_pkg;

  // Port widths
  localparam int CW_W   = 63;  // codeword port
  localparam int DATA_W = 57;  // packed data port
  localparam int LEN_W  = 6;   // code length register
  localparam int SYN_W  = 6;   // syndrome

  // Default for the largest supported codeword
  localparam int MAX_CODE_BITS_DEF = 63;

  // Code length after reset
  localparam logic [LEN_W-1:0] CODE_LEN_RST = LEN_W'(63);

  // Result flags handed from the correct stage to the output stage
  typedef struct packed {
    logic corrected;
    logic uncorrectable;
  } hsd_flags_t;

  // One-based codeword position of the idx-th data bit (0 if none below 64)
  function automatic int data_pos(input int idx);
    int p;
    int n;
    int res;
    n   = 0;
    res = 0;
    for (p = 1; p < 64; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (n == idx && res == 0) begin
          res = p;
        end
        n++;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hsd_syndrome.sv
// ----------------------------------------------------------------------------
// hsd_syndrome
// Stage 1: clamps the code length, masks unused codeword bits and computes
// the syndrome as the XOR of the positions of all set bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_syndrome
  import hsd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire logic [LEN_W-1:0]         code_len,
  input  wire logic [MAX_CODE_BITS-1:0] codeword,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output logic [MAX_CODE_BITS-1:0]      word,
  output logic [SYN_W-1:0]              syn,
  output logic [LEN_W-1:0]              len
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

  logic [LEN_W-1:0]         len_eff;
  logic [MAX_CODE_BITS-1:0] word_m;
  logic [SYN_W-1:0]         syn_c;

  // Saturate the length at the supported maximum
  assign len_eff = (code_len > MAX_LEN) ? MAX_LEN : code_len;

  // Drop bits at or above the length in use
  always_comb begin
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      word_m[i] = codeword[i] & (LEN_W'(i) < len_eff);
    end
  end

  // Syndrome bit k: parity over positions with bit k set
  always_comb begin
    for (int k = 0; k < SYN_W; k++) begin
      syn_c[k] = 1'b0;
      for (int i = 0; i < MAX_CODE_BITS; i++) begin
        if ((((i + 1) >> k) & 1) != 0) begin
          syn_c[k] = syn_c[k] ^ word_m[i];
        end
      end
    end
  end

  // Stage advances when empty or when downstream takes the word
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word <= word_m;
      syn  <= syn_c;
      len  <= len_eff;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsd_correct.sv
// ----------------------------------------------------------------------------
// hsd_correct
// Stage 2: checks the syndrome against the length and flips the named bit,
// or flags the word as uncorrectable when it points past the length.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_correct
  import hsd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire logic [MAX_CODE_BITS-1:0] word_in,
  input  wire logic [SYN_W-1:0]         syn_in,
  input  wire logic [LEN_W-1:0]         len_in,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output logic [MAX_CODE_BITS-1:0]      word,
  output logic [SYN_W-1:0]              syn,
  output hsd_flags_t                    flags
);

  logic                     fix;
  logic [MAX_CODE_BITS-1:0] word_c;
  hsd_flags_t               flags_c;

  // Correctable when the syndrome names a position in use
  assign fix = (syn_in != '0) && (syn_in <= len_in);

  assign flags_c.corrected     = fix;
  assign flags_c.uncorrectable = (syn_in > len_in);

  // One-hot flip of the erroneous position
  always_comb begin
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      word_c[i] = word_in[i] ^ (fix && (syn_in == SYN_W'(i + 1)));
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word  <= word_c;
      syn   <= syn_in;
      flags <= flags_c;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsd_pack.sv
// ----------------------------------------------------------------------------
// hsd_pack
// Stage 3: packs the data positions in ascending order into the result and
// holds the finished word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_pack
  import hsd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire logic [MAX_CODE_BITS-1:0] word_in,
  input  wire logic [SYN_W-1:0]         syn_in,
  input  wire hsd_flags_t               flags_in,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output logic [DATA_W-1:0]             data_bits,
  output logic [SYN_W-1:0]              syndrome,
  output hsd_flags_t                    flags
);

  logic [DATA_W-1:0] data_c;

  // Fixed routing of non-power-of-two positions; unused slots read zero
  for (genvar j = 0; j < DATA_W; j++) begin : g_data
    localparam int POS = data_pos(j);
    if (POS >= 1 && POS <= MAX_CODE_BITS) begin : g_on
      assign data_c[j] = word_in[POS-1];
    end else begin : g_off
      assign data_c[j] = 1'b0;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_bits <= data_c;
      syndrome  <= syn_in;
      flags     <= flags_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hamming_sec_decoder_top.sv
// ----------------------------------------------------------------------------
// hamming_sec_decoder_top
// Single-error-correcting decoder for a shortened Hamming code of
// programmable length.
// ----------------------------------------------------------------------------
// Usage: takes one codeword per clock while in_ready is high and returns
// one result word per codeword, in order; each codeword passes through
// the stage 1, stage 2 and output registers before its result is valid
// at the output. The work runs through three registered stages: syndrome
// (masking plus the per-check XOR trees), correction (length compare and
// bit flip) and packing into the output register. Each stage advances when
// it is empty or its successor takes its word, so in_ready follows
// out_ready through the chain and a full pipeline sustains one word per
// cycle. code_len is written through the cfg port and must only change
// while no word is in flight; values above MAX_CODE_BITS act as
// MAX_CODE_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_sec_decoder_top
  import hsd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // config write
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [LEN_W-1:0]  cfg_data,
  // codeword in
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CW_W-1:0]   codeword,
  // result out
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      data_bits,
  output logic [SYN_W-1:0]       syndrome,
  output logic                   corrected,
  output logic                   uncorrectable
);

  logic [LEN_W-1:0]         code_len;

  logic                     s1_valid;
  logic                     s1_ready;
  logic [MAX_CODE_BITS-1:0] s1_word;
  logic [SYN_W-1:0]         s1_syn;
  logic [LEN_W-1:0]         s1_len;

  logic                     s2_valid;
  logic                     s2_ready;
  logic [MAX_CODE_BITS-1:0] s2_word;
  logic [SYN_W-1:0]         s2_syn;
  hsd_flags_t               s2_flags;

  hsd_flags_t               out_flags;

  // Length register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_len <= CODE_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      code_len <= cfg_data;
    end
  end

  // Stage 1: syndrome
  hsd_syndrome #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_syndrome (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .code_len (code_len),
    .codeword (codeword[MAX_CODE_BITS-1:0]),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .word     (s1_word),
    .syn      (s1_syn),
    .len      (s1_len)
  );

  // Stage 2: correction
  hsd_correct #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_correct (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .word_in  (s1_word),
    .syn_in   (s1_syn),
    .len_in   (s1_len),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .word     (s2_word),
    .syn      (s2_syn),
    .flags    (s2_flags)
  );

  // Stage 3: packing and output register
  hsd_pack #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_pack (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s2_valid),
    .up_ready  (s2_ready),
    .word_in   (s2_word),
    .syn_in    (s2_syn),
    .flags_in  (s2_flags),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .data_bits (data_bits),
    .syndrome  (syndrome),
    .flags     (out_flags)
  );

  assign corrected     = out_flags.corrected;
  assign uncorrectable = out_flags.uncorrectable;

`ifndef SYNTHESIS
  // A flagged result always carries a nonzero syndrome
  a_flag_needs_syn: assert property (@(posedge clk) disable iff (rst)
    out_valid && (corrected || uncorrectable) |-> syndrome != '0)
    else $error("flag set with zero syndrome");

  // Corrected and uncorrectable never together
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(corrected && uncorrectable))
    else $error("corrected and uncorrectable both set");

  // Nonzero syndrome always raises exactly one flag
  a_syn_flagged: assert property (@(posedge clk) disable iff (rst)
    out_valid && syndrome != '0 |-> corrected || uncorrectable)
    else $error("nonzero syndrome without a flag");

  // An accepted codeword lands in stage 1
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted codeword lost at stage 1");
`endif

endmodule

`default_nettype wire
